### hw/rtl/jadm_pkg.sv
// ----------------------------------------------------------------------------
// Joystick axis deadzone map - shared definitions
// Widths, register indexes, saturation bounds and the divider cell word.
// ----------------------------------------------------------------------------
package jadm_pkg;

  localparam int SAMPLE_BITS     = 10;
  localparam int CURVE_FRAC_BITS = 10;

  localparam int DZ_BITS     = SAMPLE_BITS - 1;
  localparam int OUT_W       = 16;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int RNG_W       = SAMPLE_BITS + 2;
  localparam int REM_W       = SAMPLE_BITS + 1;
  localparam int MAG_W       = 2 * SAMPLE_BITS;
  localparam int PROD_W      = 2 * SAMPLE_BITS + CURVE_FRAC_BITS;
  localparam int DIFF_W      = OUT_W + 1;
  localparam int NUM_W       = 2 * SAMPLE_BITS + 16;
  localparam int SUM_W       = NUM_W + 2;
  localparam int CURVE_CELLS = SAMPLE_BITS + CURVE_FRAC_BITS;
  localparam int MAP_CELLS   = NUM_W;

  localparam logic signed [OUT_W-1:0] OUT_HI = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_LO = {1'b1, {(OUT_W-1){1'b0}}};
  localparam logic signed [SUM_W-1:0] SUM_HI = SUM_W'(OUT_HI);
  localparam logic signed [SUM_W-1:0] SUM_LO = SUM_W'(OUT_LO);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_MIN,
    REG_IN_CENTER,
    REG_IN_MAX,
    REG_DEADZONE,
    REG_OUT_MIN,
    REG_OUT_MAX,
    REG_CURVE_EN
  } cfg_reg_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [NUM_W-1:0] dq;
    logic [REM_W-1:0] dvs;
  } div_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0]   m;
    logic signed [RNG_W-1:0]  rng;
    logic                     fwd;
  } cv_side_t;

  typedef struct packed {
    logic neg;
    logic zero;
    logic one;
    logic fwd;
  } mp_side_t;

endpackage

### hw/rtl/jadm_div_cell.sv
// ----------------------------------------------------------------------------
// Joystick axis deadzone map - divider cell
// One restoring division step: shift in the next dividend bit, subtract the
// divisor when it fits, shift the quotient bit in, hand on to the next cell.
// ----------------------------------------------------------------------------
module jadm_div_cell (
  input  logic           clk,
  input  logic           en,
  input  jadm_pkg::div_t cell_in,
  output jadm_pkg::div_t cell_out
);
  import jadm_pkg::*;

  logic [REM_W:0] trial;
  logic           fits;
  div_t           cell_nxt;
  div_t           cell_r;

  always_comb begin
    trial        = {cell_in.rem, cell_in.dq[NUM_W-1]};
    fits         = trial >= {1'b0, cell_in.dvs};
    cell_nxt.dvs = cell_in.dvs;
    cell_nxt.dq  = {cell_in.dq[NUM_W-2:0], fits};
    if (fits) begin
      cell_nxt.rem = REM_W'(trial - {1'b0, cell_in.dvs});
    end else begin
      cell_nxt.rem = trial[REM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_out = cell_r;

endmodule

### hw/rtl/joystick_axis_deadzone_map.sv
// ----------------------------------------------------------------------------
// Joystick axis deadzone map - top level
// Clamps a raw axis sample, removes center and deadzone, optionally squares
// the response, and maps the magnitude linearly onto [out_min, out_max].
//
// Usage:
//   in_valid/in_ready/in_sample carries one converter reading per request.
//   out_valid/out_ready carries out_value and out_forward, one per sample.
//   cfg_wr_en/cfg_index/cfg_wdata writes a register; write only
//   while no request is in flight. Unknown indexes are ignored.
// Timing:
//   The pipeline holds two rows of divider cells: SAMPLE_BITS + CURVE_FRAC_BITS cells
//   for the curve quotient and 2*SAMPLE_BITS + 16 cells for the map quotient.
//   Throughput is one sample per cycle while the pipeline is not stalled.
// Reset:
//   Registers return to their defaults and the pipeline empties.
// Stall:
//   The output holds while out_ready is low; one more result lands in a skid
//   register, then in_ready drops and the whole pipeline holds.
// ----------------------------------------------------------------------------
module joystick_axis_deadzone_map (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [jadm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [jadm_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [jadm_pkg::SAMPLE_BITS-1:0]    in_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [jadm_pkg::OUT_W-1:0]   out_value,
  output logic                                out_forward
);
  import jadm_pkg::*;

  logic [SAMPLE_BITS-1:0]  in_min_r;
  logic [SAMPLE_BITS-1:0]  in_center_r;
  logic [SAMPLE_BITS-1:0]  in_max_r;
  logic [DZ_BITS-1:0]      deadzone_r;
  logic signed [OUT_W-1:0] out_min_r;
  logic signed [OUT_W-1:0] out_max_r;
  logic                    curve_en_r;

  logic en;
  logic in_fire;

  logic [SAMPLE_BITS-1:0]  x_lo;
  logic [SAMPLE_BITS-1:0]  x_cl;
  logic signed [SAMPLE_BITS:0] s1_d_nxt, s1_d_r;
  logic signed [RNG_W-1:0] s1_rf_nxt, s1_rf_r;
  logic signed [RNG_W-1:0] s1_rr_nxt, s1_rr_r;
  logic                    s1_v_r;

  logic [SAMPLE_BITS:0]    neg_d;
  logic [SAMPLE_BITS-1:0]  mag2;
  logic [SAMPLE_BITS:0]    m_diff;
  logic                    s2_fwd_nxt, s2_fwd_r;
  logic [SAMPLE_BITS-1:0]  s2_m_nxt, s2_m_r;
  logic signed [RNG_W-1:0] s2_rng_nxt, s2_rng_r;
  logic                    s2_v_r;

  div_t                    cv_head;
  div_t                    cv_q [CURVE_CELLS];
  cv_side_t                cv_sb_r [CURVE_CELLS];
  logic [CURVE_CELLS-1:0]  cv_v_r;
  cv_side_t                cv_tail_sb;
  logic [CURVE_CELLS-1:0]  cv_t;

  logic [PROD_W-1:0]       s3_p_nxt, s3_p_r;
  logic                    s3_apply_nxt, s3_apply_r;
  logic [SAMPLE_BITS-1:0]  s3_m_r;
  logic signed [RNG_W-1:0] s3_rng_r;
  logic                    s3_fwd_r;
  logic                    s3_v_r;

  logic [MAG_W-1:0]        mf;
  logic [MAG_W-1:0]        s4_mm1_nxt, s4_mm1_r;
  logic                    s4_zero_nxt, s4_zero_r;
  logic                    s4_one_nxt, s4_one_r;
  logic signed [RNG_W-1:0] s4_rng_r;
  logic                    s4_fwd_r;
  logic                    s4_v_r;

  logic signed [DIFF_W-1:0]      diff;
  logic signed [MAG_W+DIFF_W:0]  prod_full;
  logic signed [NUM_W:0]         s5_n_nxt, s5_n_r;
  logic signed [RNG_W-1:0]       s5_dm1_nxt, s5_dm1_r;
  logic                          s5_zero_r, s5_one_r, s5_fwd_r;
  logic                          s5_v_r;

  logic [NUM_W:0]          neg_n;
  logic [RNG_W-1:0]        neg_dm;
  logic [NUM_W-1:0]        s6_nmag_nxt, s6_nmag_r;
  logic [REM_W-1:0]        s6_dmag_nxt, s6_dmag_r;
  logic                    s6_neg_nxt, s6_neg_r;
  logic                    s6_zero_r, s6_one_r, s6_fwd_r;
  logic                    s6_v_r;

  div_t                    mp_head;
  div_t                    mp_q [MAP_CELLS];
  mp_side_t                mp_sb_r [MAP_CELLS];
  logic [MAP_CELLS-1:0]    mp_v_r;
  mp_side_t                mp_tail_sb;
  logic [NUM_W-1:0]        qmag;

  logic signed [NUM_W:0]   s7_q_nxt, s7_q_r;
  logic                    s7_zero_r, s7_one_r, s7_fwd_r;
  logic                    s7_v_r;

  logic signed [SUM_W-1:0] sum;
  logic signed [OUT_W-1:0] res_sat;
  logic signed [OUT_W-1:0] res;

  logic                    out_valid_r, skid_valid_r;
  logic signed [OUT_W-1:0] out_value_r, skid_value_r;
  logic                    out_fwd_r, skid_fwd_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_min_r    <= '0;
      in_center_r <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      in_max_r    <= '1;
      deadzone_r  <= '0;
      out_min_r   <= '0;
      out_max_r   <= OUT_W'(255);
      curve_en_r  <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IN_MIN:    in_min_r    <= cfg_wdata[SAMPLE_BITS-1:0];
        REG_IN_CENTER: in_center_r <= cfg_wdata[SAMPLE_BITS-1:0];
        REG_IN_MAX:    in_max_r    <= cfg_wdata[SAMPLE_BITS-1:0];
        REG_DEADZONE:  deadzone_r  <= cfg_wdata[DZ_BITS-1:0];
        REG_OUT_MIN:   out_min_r   <= cfg_wdata[OUT_W-1:0];
        REG_OUT_MAX:   out_max_r   <= cfg_wdata[OUT_W-1:0];
        REG_CURVE_EN:  curve_en_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign en       = !skid_valid_r;
  assign in_ready = en;
  assign in_fire  = in_valid && in_ready;

  // clamp, center offset, side ranges
  always_comb begin
    x_lo      = (in_sample < in_min_r) ? in_min_r : in_sample;
    x_cl      = (x_lo > in_max_r) ? in_max_r : x_lo;
    s1_d_nxt  = $signed({1'b0, x_cl}) - $signed({1'b0, in_center_r});
    s1_rf_nxt = $signed({2'b0, in_max_r}) - $signed({2'b0, in_center_r})
              - $signed({3'b0, deadzone_r});
    s1_rr_nxt = $signed({2'b0, in_center_r}) - $signed({2'b0, in_min_r})
              - $signed({3'b0, deadzone_r});
  end

  // direction, magnitude less deadzone
  always_comb begin
    s2_fwd_nxt = !s1_d_r[SAMPLE_BITS];
    neg_d      = -s1_d_r;
    mag2       = s2_fwd_nxt ? s1_d_r[SAMPLE_BITS-1:0] : neg_d[SAMPLE_BITS-1:0];
    m_diff     = {1'b0, mag2} - {2'b0, deadzone_r};
    s2_m_nxt   = m_diff[SAMPLE_BITS] ? '0 : m_diff[SAMPLE_BITS-1:0];
    s2_rng_nxt = s2_fwd_nxt ? s1_rf_r : s1_rr_r;
  end

  always_comb begin
    cv_head.rem = '0;
    cv_head.dq  = {s2_m_r, {(NUM_W-SAMPLE_BITS){1'b0}}};
    cv_head.dvs = s2_rng_r[REM_W-1:0];
  end

  for (genvar i = 0; i < CURVE_CELLS; i++) begin : g_cv
    if (i == 0) begin : g_first
      jadm_div_cell u_cell (.clk(clk), .en(en), .cell_in(cv_head), .cell_out(cv_q[i]));
    end else begin : g_next
      jadm_div_cell u_cell (.clk(clk), .en(en), .cell_in(cv_q[i-1]), .cell_out(cv_q[i]));
    end
  end

  assign cv_tail_sb = cv_sb_r[CURVE_CELLS-1];
  assign cv_t       = cv_q[CURVE_CELLS-1].dq[CURVE_CELLS-1:0];

  // curve product and select
  always_comb begin
    s3_p_nxt     = {{SAMPLE_BITS{1'b0}}, cv_t} * {{CURVE_CELLS{1'b0}}, cv_tail_sb.m};
    s3_apply_nxt = curve_en_r && !cv_tail_sb.rng[RNG_W-1] && (cv_tail_sb.rng != '0);
  end

  always_comb begin
    mf          = s3_apply_r ? s3_p_r[PROD_W-1:CURVE_FRAC_BITS]
                             : {{SAMPLE_BITS{1'b0}}, s3_m_r};
    s4_zero_nxt = (mf == '0);
    s4_one_nxt  = (s3_rng_r == RNG_W'(1));
    s4_mm1_nxt  = mf - MAG_W'(1);
  end

  // map numerator and divisor
  always_comb begin
    diff       = $signed({out_max_r[OUT_W-1], out_max_r})
               - $signed({out_min_r[OUT_W-1], out_min_r});
    prod_full  = $signed({1'b0, s4_mm1_r}) * diff;
    s5_n_nxt   = prod_full[NUM_W:0];
    s5_dm1_nxt = s4_rng_r - RNG_W'(1);
  end

  always_comb begin
    neg_n       = -s5_n_r;
    neg_dm      = -s5_dm1_r;
    s6_nmag_nxt = s5_n_r[NUM_W] ? neg_n[NUM_W-1:0] : s5_n_r[NUM_W-1:0];
    s6_dmag_nxt = s5_dm1_r[RNG_W-1] ? neg_dm[REM_W-1:0] : s5_dm1_r[REM_W-1:0];
    s6_neg_nxt  = s5_n_r[NUM_W] ^ s5_dm1_r[RNG_W-1];
  end

  always_comb begin
    mp_head.rem = '0;
    mp_head.dq  = s6_nmag_r;
    mp_head.dvs = s6_dmag_r;
  end

  for (genvar i = 0; i < MAP_CELLS; i++) begin : g_mp
    if (i == 0) begin : g_first
      jadm_div_cell u_cell (.clk(clk), .en(en), .cell_in(mp_head), .cell_out(mp_q[i]));
    end else begin : g_next
      jadm_div_cell u_cell (.clk(clk), .en(en), .cell_in(mp_q[i-1]), .cell_out(mp_q[i]));
    end
  end

  assign mp_tail_sb = mp_sb_r[MAP_CELLS-1];
  assign qmag       = mp_q[MAP_CELLS-1].dq;

  always_comb begin
    s7_q_nxt = mp_tail_sb.neg ? -{1'b0, qmag} : {1'b0, qmag};
  end

  // offset, saturate, special cases
  always_comb begin
    sum = $signed({s7_q_r[NUM_W], s7_q_r})
        + $signed({{(SUM_W-OUT_W){out_min_r[OUT_W-1]}}, out_min_r});
    if (sum > SUM_HI) begin
      res_sat = OUT_HI;
    end else if (sum < SUM_LO) begin
      res_sat = OUT_LO;
    end else begin
      res_sat = sum[OUT_W-1:0];
    end
    if (s7_zero_r) begin
      res = '0;
    end else if (s7_one_r) begin
      res = out_max_r;
    end else begin
      res = res_sat;
    end
  end

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      cv_v_r <= '0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
      mp_v_r <= '0;
      s7_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_fire;
      s2_v_r <= s1_v_r;
      cv_v_r <= {cv_v_r[CURVE_CELLS-2:0], s2_v_r};
      s3_v_r <= cv_v_r[CURVE_CELLS-1];
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
      s6_v_r <= s5_v_r;
      mp_v_r <= {mp_v_r[MAP_CELLS-2:0], s6_v_r};
      s7_v_r <= mp_v_r[MAP_CELLS-1];
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (en) begin
      s1_d_r  <= s1_d_nxt;
      s1_rf_r <= s1_rf_nxt;
      s1_rr_r <= s1_rr_nxt;

      s2_fwd_r <= s2_fwd_nxt;
      s2_m_r   <= s2_m_nxt;
      s2_rng_r <= s2_rng_nxt;

      cv_sb_r[0].m   <= s2_m_r;
      cv_sb_r[0].rng <= s2_rng_r;
      cv_sb_r[0].fwd <= s2_fwd_r;
      for (int i = 1; i < CURVE_CELLS; i++) begin
        cv_sb_r[i] <= cv_sb_r[i-1];
      end

      s3_p_r     <= s3_p_nxt;
      s3_apply_r <= s3_apply_nxt;
      s3_m_r     <= cv_tail_sb.m;
      s3_rng_r   <= cv_tail_sb.rng;
      s3_fwd_r   <= cv_tail_sb.fwd;

      s4_mm1_r  <= s4_mm1_nxt;
      s4_zero_r <= s4_zero_nxt;
      s4_one_r  <= s4_one_nxt;
      s4_rng_r  <= s3_rng_r;
      s4_fwd_r  <= s3_fwd_r;

      s5_n_r    <= s5_n_nxt;
      s5_dm1_r  <= s5_dm1_nxt;
      s5_zero_r <= s4_zero_r;
      s5_one_r  <= s4_one_r;
      s5_fwd_r  <= s4_fwd_r;

      s6_nmag_r <= s6_nmag_nxt;
      s6_dmag_r <= s6_dmag_nxt;
      s6_neg_r  <= s6_neg_nxt;
      s6_zero_r <= s5_zero_r;
      s6_one_r  <= s5_one_r;
      s6_fwd_r  <= s5_fwd_r;

      mp_sb_r[0].neg  <= s6_neg_r;
      mp_sb_r[0].zero <= s6_zero_r;
      mp_sb_r[0].one  <= s6_one_r;
      mp_sb_r[0].fwd  <= s6_fwd_r;
      for (int i = 1; i < MAP_CELLS; i++) begin
        mp_sb_r[i] <= mp_sb_r[i-1];
      end

      s7_q_r    <= s7_q_nxt;
      s7_zero_r <= mp_tail_sb.zero;
      s7_one_r  <= mp_tail_sb.one;
      s7_fwd_r  <= mp_tail_sb.fwd;
    end
  end

  // output register and skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= s7_v_r;
      end
    end else if (en && s7_v_r) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_value_r <= skid_value_r;
        out_fwd_r   <= skid_fwd_r;
      end else begin
        out_value_r <= res;
        out_fwd_r   <= s7_fwd_r;
      end
    end else if (en) begin
      skid_value_r <= res;
      skid_fwd_r   <= s7_fwd_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_value   = out_value_r;
  assign out_forward = out_fwd_r;

endmodule
